@@ src/ip_address_text_validator_core_defines.svh @@
// ----------------------------------------------------------------------------
// ip_address_text_validator_core_defines
// Assertion macros used by the checker file of the validator.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_VALIDATOR_CORE_DEFINES_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define IPV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define IPV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ipv_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv_pkg
// Character classes, constants and stage types of the address validator.
// ----------------------------------------------------------------------------
package ipv_pkg;

    localparam int CHAR_W = 16;

    // operation codes, read on the final character of a string
    localparam logic OP_IPV4 = 1'b0;
    localparam logic OP_IPV6 = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO = 16'h0030;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI = 16'h0039;  // '9'
    localparam logic [CHAR_W-1:0] CHAR_UPPER_LO = 16'h0041;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_UPPER_HI = 16'h0046;  // 'F'
    localparam logic [CHAR_W-1:0] CHAR_LOWER_LO = 16'h0061;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_LOWER_HI = 16'h0066;  // 'f'
    localparam logic [CHAR_W-1:0] CHAR_COLON    = 16'h003A;  // ':'
    localparam logic [CHAR_W-1:0] CHAR_DOT      = 16'h002E;  // '.'

    // group length counter, saturates at its top value
    localparam int LEN_W = 3;
    localparam logic [LEN_W-1:0] LEN_SAT       = 3'd7;
    localparam logic [LEN_W-1:0] HEX_GROUP_MAX = 3'd4;
    localparam logic [LEN_W-1:0] DEC_GROUP_MAX = 3'd3;

    localparam logic [1:0] QUAD_DOTS = 2'd3;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_HEX_LETTER,
        CLS_COLON,
        CLS_DOT,
        CLS_OTHER
    } t_cls;

    // one registered, classified item
    typedef struct packed {
        t_cls cls;
        logic operation;
        logic last_char;
    } t_item;

    function automatic t_cls classify(input logic [CHAR_W-1:0] c);
        t_cls k;
        if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
            k = CLS_DIGIT;
        end else if ((c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI)
                  || (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI)) begin
            k = CLS_HEX_LETTER;
        end else if (c == CHAR_COLON) begin
            k = CLS_COLON;
        end else if (c == CHAR_DOT) begin
            k = CLS_DOT;
        end else begin
            k = CLS_OTHER;
        end
        return k;
    endfunction

endpackage

@@ src/ipv_class.sv @@
// ----------------------------------------------------------------------------
// ipv_class
// Input register: classifies the incoming character and holds the item.
// ----------------------------------------------------------------------------
module ipv_class (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_operation,
    input  logic [ipv_pkg::CHAR_W-1:0] i_char_code,
    input  logic                       i_last_char,
    input  logic                       i_take,
    output logic                       o_valid,
    output ipv_pkg::t_item             o_item
);

    logic           r_valid;
    ipv_pkg::t_item r_item;
    logic           load;

    // slot frees when downstream takes the held item
    assign o_in_stall = r_valid && !i_take;
    assign load       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= load || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.cls       <= ipv_pkg::classify(i_char_code);
            r_item.operation <= i_operation;
            r_item.last_char <= i_last_char;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ src/ipv_parse.sv @@
// ----------------------------------------------------------------------------
// ipv_parse
// Recognizer state update and result register.
// ----------------------------------------------------------------------------
module ipv_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ipv_pkg::t_item i_item,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_address_valid
);

    typedef enum logic [2:0] {
        PH_START,
        PH_GROUP_NC,   // group, no colon seen yet
        PH_GROUP,
        PH_LEAD_COLON,
        PH_COLON,
        PH_DCOLON,
        PH_DOT_V4,
        PH_DOT_V6
    } t_phase;

    t_phase                    r_phase, n_phase;
    logic [ipv_pkg::LEN_W-1:0] r_len, n_len;
    logic                      r_dec, n_dec;
    logic [1:0]                r_dots, n_dots;
    logic                      r_dcolon, n_dcolon;
    logic                      r_err, n_err;
    logic                      r_out_valid;
    logic                      r_addr_ok, n_addr_ok;

    logic is_dec;
    logic quad_done;
    logic v4ok, v6ok;
    logic finish;

    // a string end needs the result slot; other items always move on
    assign o_take = i_valid && (!i_item.last_char || !r_out_valid || !i_out_stall);
    assign finish = o_take && i_item.last_char;
    assign is_dec = (i_item.cls == ipv_pkg::CLS_DIGIT);

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_dec    = r_dec;
        n_dots   = r_dots;
        n_dcolon = r_dcolon;
        n_err    = r_err;
        if (!r_err) begin
            unique case (i_item.cls) inside
                ipv_pkg::CLS_DIGIT, ipv_pkg::CLS_HEX_LETTER: begin
                    unique case (r_phase) inside
                        PH_START: begin
                            n_phase = PH_GROUP_NC;
                            n_len   = 3'd1;
                            n_dec   = is_dec;
                        end
                        PH_GROUP_NC, PH_GROUP: begin
                            if (r_len < ipv_pkg::LEN_SAT) n_len = r_len + 3'd1;
                            if (!is_dec) n_dec = 1'b0;
                        end
                        PH_COLON, PH_DCOLON: begin
                            n_phase = PH_GROUP;
                            n_len   = 3'd1;
                            n_dec   = is_dec;
                        end
                        PH_DOT_V4, PH_DOT_V6: begin
                            if (!is_dec || r_len >= ipv_pkg::DEC_GROUP_MAX) n_err = 1'b1;
                            else n_len = r_len + 3'd1;
                        end
                        default: n_err = 1'b1;
                    endcase
                end
                ipv_pkg::CLS_COLON: begin
                    if (r_phase == PH_START) begin
                        n_phase = PH_LEAD_COLON;
                    end else if (r_phase == PH_GROUP_NC || r_phase == PH_GROUP) begin
                        if (r_len > ipv_pkg::HEX_GROUP_MAX) n_err = 1'b1;
                        else n_phase = PH_COLON;
                    end else if ((r_phase == PH_LEAD_COLON || r_phase == PH_COLON)
                                 && !r_dcolon) begin
                        n_phase  = PH_DCOLON;
                        n_dcolon = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                ipv_pkg::CLS_DOT: begin
                    if (r_phase == PH_GROUP_NC || r_phase == PH_GROUP) begin
                        if (!r_dec || r_len == 3'd0 || r_len > ipv_pkg::DEC_GROUP_MAX) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase = (r_phase == PH_GROUP_NC) ? PH_DOT_V4 : PH_DOT_V6;
                            n_dots  = 2'd1;
                            n_len   = 3'd0;
                        end
                    end else if (r_phase == PH_DOT_V4 || r_phase == PH_DOT_V6) begin
                        if (r_len == 3'd0 || r_dots == ipv_pkg::QUAD_DOTS) begin
                            n_err = 1'b1;
                        end else begin
                            n_dots = r_dots + 2'd1;
                            n_len  = 3'd0;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: n_err = 1'b1;
            endcase
        end
    end

    // verdict from the state after this character
    always_comb begin
        quad_done = (n_dots == ipv_pkg::QUAD_DOTS) && (n_len != 3'd0);
        v4ok      = !n_err && (n_phase == PH_DOT_V4) && quad_done;
        v6ok      = 1'b0;
        if (!n_err && !v4ok) begin
            unique case (n_phase) inside
                PH_GROUP_NC, PH_GROUP: v6ok = (n_len <= ipv_pkg::HEX_GROUP_MAX);
                PH_DCOLON:             v6ok = 1'b1;
                PH_DOT_V6:             v6ok = quad_done;
                default:               v6ok = 1'b0;
            endcase
        end
        n_addr_ok = (i_item.operation == ipv_pkg::OP_IPV6) ? v6ok : v4ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_len       <= '0;
            r_dec       <= 1'b1;
            r_dots      <= '0;
            r_dcolon    <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_phase   <= PH_START;
                r_len     <= '0;
                r_dec     <= 1'b1;
                r_dots    <= '0;
                r_dcolon  <= 1'b0;
                r_err     <= 1'b0;
                r_addr_ok <= n_addr_ok;
            end else if (o_take) begin
                r_phase  <= n_phase;
                r_len    <= n_len;
                r_dec    <= n_dec;
                r_dots   <= n_dots;
                r_dcolon <= n_dcolon;
                r_err    <= n_err;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_address_valid = r_addr_ok;

endmodule

@@ src/ip_address_text_validator_core.sv @@
// ----------------------------------------------------------------------------
// ip_address_text_validator_core
// Checks IPv4 dotted-quad or IPv6 address text, one character per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to core   | i_in_valid / o_in_stall   | i_operation, i_char_code,
//          |           |                           | i_last_char
//  out     | from core | o_out_valid / i_out_stall | o_address_valid
//
//  One character item per cycle is accepted while o_in_stall stays low.
//  The verdict for a string is loaded after its last character is accepted:
//  the character passes the input register, then the recognizer update
//  loads the verdict into the result register and sets o_out_valid.
//  Reset (synchronous, i_rst_n low) returns the recognizer to start of string
//  and empties both registers.
//  A stall on the result side holds the verdict; characters that do not end
//  a string keep flowing, and only a string end waits for the result slot.
// ----------------------------------------------------------------------------
module ip_address_text_validator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,   // 0 IPv4, 1 IPv6, sampled at string end
    input  logic [15:0] i_char_code,
    input  logic        i_last_char,
    // verdict items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_address_valid
);

    logic           s1_valid;
    ipv_pkg::t_item s1_item;
    logic           s1_take;

    // stage 1: register and classify the character
    ipv_class u_class (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_take      (s1_take),
        .o_valid     (s1_valid),
        .o_item      (s1_item)
    );

    // stage 2: advance the recognizer; string end loads the verdict
    ipv_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s1_valid),
        .i_item          (s1_item),
        .o_take          (s1_take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_address_valid (o_address_valid)
    );

endmodule

@@ src/ipv_checker.sv @@
// ----------------------------------------------------------------------------
// ipv_checker
// Port-level checks of the validator core, bound to the top level.
// ----------------------------------------------------------------------------
`include "ip_address_text_validator_core_defines.svh"

module ipv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_char,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_address_valid
);

    logic in_acc_last;
    logic out_held;

    assign in_acc_last = i_in_valid && !o_in_stall && i_last_char;
    assign out_held    = o_out_valid && i_out_stall;

    // held verdict stays up
    `IPV_ASSERT_NEXT(a_out_hold, out_held, o_out_valid, "verdict dropped")
    // held verdict keeps its value
    `IPV_ASSERT_NEXT(a_out_stable, out_held, $stable(o_address_valid), "verdict changed")
    // input only backs up behind a pending, stalled verdict
    `IPV_ASSERT_IMPL(a_stall_cause, o_in_stall, out_held, "spurious input stall")
    // a fresh verdict comes from an accepted string end, past the input register and the recognizer update
    `IPV_ASSERT_IMPL(a_verdict_src, $rose(o_out_valid), $past(in_acc_last, 2), "stray verdict")

endmodule

bind ip_address_text_validator_core ipv_checker u_ipv_checker (.*);

@@ bench/ip_address_text_validator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_address_text_validator_core_tb
// Streams address strings into the validator one character item at a time,
// predicts each verdict with an in-bench recognizer and compares it with
// every verdict item that leaves the core. The sender runs in bursts and the
// receiver stalls on its own pattern, with one long hold-off that backs the
// core up onto its input.
// ----------------------------------------------------------------------------
module ip_address_text_validator_core_tb;

    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // recognizer phases of the predictor
    typedef enum logic [3:0] {
        SCAN_START,
        SCAN_LEAD_GROUP,    // first group, no colon seen yet
        SCAN_GROUP,         // hex group after a colon
        SCAN_LEAD_COLON,
        SCAN_COLON,
        SCAN_DCOLON,
        SCAN_QUAD_V4,       // dotted quad from the first group
        SCAN_QUAD_V6        // dotted quad after a colon
    } t_scan;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_operation = 1'b0;
    logic [15:0] i_char_code = '0;
    logic        i_last_char = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_address_valid;

    // predictor state
    t_scan       scan_phase = SCAN_START;
    logic [2:0]  grp_len = '0;
    logic        grp_decimal = 1'b1;
    logic [1:0]  quad_dots = '0;
    logic        has_dcolon = 1'b0;
    logic        in_error = 1'b0;

    logic        verdict_q[$];
    logic [15:0] str_buf[$];

    int error_count = 0;
    int chars_sent = 0;
    int cycle_count = 0;
    int burst_left = 0;
    bit sender_gaps = 1'b1;

    // receiver stall pattern
    int hold_request = 0;
    int hold_left = 0;
    int seg_left = 0;
    int stall_pct = 0;

    ip_address_text_validator_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_char_code     (i_char_code),
        .i_last_char     (i_last_char),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_address_valid (o_address_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ip_address_text_validator_core_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic clear_scan();
        scan_phase  = SCAN_START;
        grp_len     = '0;
        grp_decimal = 1'b1;
        quad_dots   = '0;
        has_dcolon  = 1'b0;
        in_error    = 1'b0;
    endtask

    task automatic scan_char(input logic [15:0] c);
        bit dec;
        bit hexl;
        dec  = (c >= ipv_pkg::CHAR_DIGIT_LO && c <= ipv_pkg::CHAR_DIGIT_HI);
        hexl = (c >= ipv_pkg::CHAR_UPPER_LO && c <= ipv_pkg::CHAR_UPPER_HI)
            || (c >= ipv_pkg::CHAR_LOWER_LO && c <= ipv_pkg::CHAR_LOWER_HI);
        if (!in_error) begin
            if (dec || hexl) begin
                case (scan_phase)
                    SCAN_START: begin
                        scan_phase  = SCAN_LEAD_GROUP;
                        grp_len     = 3'd1;
                        grp_decimal = dec;
                    end
                    SCAN_LEAD_GROUP, SCAN_GROUP: begin
                        if (grp_len != ipv_pkg::LEN_SAT) grp_len++;
                        if (!dec) grp_decimal = 1'b0;
                    end
                    SCAN_COLON, SCAN_DCOLON: begin
                        scan_phase  = SCAN_GROUP;
                        grp_len     = 3'd1;
                        grp_decimal = dec;
                    end
                    SCAN_QUAD_V4, SCAN_QUAD_V6: begin
                        if (!dec || grp_len >= ipv_pkg::DEC_GROUP_MAX) in_error = 1'b1;
                        else grp_len++;
                    end
                    default: in_error = 1'b1;
                endcase
            end else if (c == ipv_pkg::CHAR_COLON) begin
                if (scan_phase == SCAN_START) begin
                    scan_phase = SCAN_LEAD_COLON;
                end else if (scan_phase == SCAN_LEAD_GROUP || scan_phase == SCAN_GROUP) begin
                    if (grp_len > ipv_pkg::HEX_GROUP_MAX) in_error = 1'b1;
                    else scan_phase = SCAN_COLON;
                end else if ((scan_phase == SCAN_LEAD_COLON || scan_phase == SCAN_COLON)
                             && !has_dcolon) begin
                    scan_phase = SCAN_DCOLON;
                    has_dcolon = 1'b1;
                end else begin
                    in_error = 1'b1;
                end
            end else if (c == ipv_pkg::CHAR_DOT) begin
                if (scan_phase == SCAN_LEAD_GROUP || scan_phase == SCAN_GROUP) begin
                    if (!grp_decimal || grp_len < 3'd1
                        || grp_len > ipv_pkg::DEC_GROUP_MAX) begin
                        in_error = 1'b1;
                    end else begin
                        scan_phase = (scan_phase == SCAN_LEAD_GROUP) ? SCAN_QUAD_V4
                                                                     : SCAN_QUAD_V6;
                        quad_dots  = 2'd1;
                        grp_len    = '0;
                    end
                end else if (scan_phase == SCAN_QUAD_V4 || scan_phase == SCAN_QUAD_V6) begin
                    if (grp_len == '0 || quad_dots >= ipv_pkg::QUAD_DOTS) begin
                        in_error = 1'b1;
                    end else begin
                        quad_dots++;
                        grp_len = '0;
                    end
                end else begin
                    in_error = 1'b1;
                end
            end else begin
                in_error = 1'b1;
            end
        end
    endtask

    function automatic logic address_verdict(input logic op);
        logic quad_ok;
        logic v4_ok;
        logic v6_ok;
        quad_ok = (quad_dots == ipv_pkg::QUAD_DOTS) && (grp_len >= 3'd1);
        v4_ok   = !in_error && scan_phase == SCAN_QUAD_V4 && quad_ok;
        v6_ok   = 1'b0;
        if (!in_error && !v4_ok) begin
            case (scan_phase)
                SCAN_LEAD_GROUP, SCAN_GROUP: v6_ok = (grp_len <= ipv_pkg::HEX_GROUP_MAX);
                SCAN_DCOLON:                 v6_ok = 1'b1;
                SCAN_QUAD_V6:                v6_ok = quad_ok;
                default:                     v6_ok = 1'b0;
            endcase
        end
        return (op == ipv_pkg::OP_IPV6) ? v6_ok : v4_ok;
    endfunction

    // ------------------------------------------------------------------------
    // Verdict checking first, then prediction: an item accepted at this edge
    // can only produce a verdict at a later edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: verdict item with nothing expected, got %0b",
                             $time, o_address_valid);
                    error_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_address_valid !== want) begin
                        $display("%0t: address_valid mismatch, expected %0b, got %0b",
                                 $time, want, o_address_valid);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                scan_char(i_char_code);
                if (i_last_char) begin
                    verdict_q.push_back(address_verdict(i_operation));
                    clear_scan();
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: segments of random stall density, plus an optional hold-off
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(5, 60);
                case ($urandom_range(2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 80;
                endcase
            end
            seg_left--;
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_char(input logic op, input logic [15:0] c, input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps) begin
                @(negedge i_clk);
                i_in_valid  = 1'b0;
                i_char_code = 16'($urandom_range(16'hFFFF));
                i_last_char = 1'($urandom_range(1));
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_operation = op;
        i_char_code = c;
        i_last_char = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        chars_sent++;
    endtask

    // operation only matters on the final character, so it is noise elsewhere
    task automatic send_str(input logic op);
        int n;
        n = str_buf.size();
        for (int i = 0; i < n; i++) begin
            send_char((i == n - 1) ? op : 1'($urandom_range(1)), str_buf[i], i == n - 1);
        end
        str_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) str_buf.push_back(16'(s[i]));
    endtask

    task automatic send_text(input logic op, input string s);
        str_buf.delete();
        put_text(s);
        send_str(op);
    endtask

    // the last item is already taken, so drop valid before idling
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Random text
    // ------------------------------------------------------------------------
    function automatic logic [15:0] rand_hex();
        int r;
        r = $urandom_range(21);
        if (r < 10) return ipv_pkg::CHAR_DIGIT_LO + 16'(r);
        else if (r < 16) return ipv_pkg::CHAR_LOWER_LO + 16'(r - 10);
        else return ipv_pkg::CHAR_UPPER_LO + 16'(r - 16);
    endfunction

    function automatic logic [15:0] pick_char();
        case ($urandom_range(7))
            2: return ipv_pkg::CHAR_COLON;
            3: return ipv_pkg::CHAR_DOT;
            4: return 16'($urandom_range(16'hFFFF));
            5: begin
                // just outside the accepted ranges, and the extremes
                case ($urandom_range(7))
                    0:       return ipv_pkg::CHAR_DIGIT_LO - 16'd1;
                    1:       return ipv_pkg::CHAR_DIGIT_HI + 16'd1;
                    2:       return ipv_pkg::CHAR_UPPER_LO - 16'd1;
                    3:       return ipv_pkg::CHAR_UPPER_HI + 16'd1;
                    4:       return ipv_pkg::CHAR_LOWER_LO - 16'd1;
                    5:       return ipv_pkg::CHAR_LOWER_HI + 16'd1;
                    6:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            6: return {8'($urandom_range(1, 255)), 8'(rand_hex())};  // aliased hex character
            default: return rand_hex();
        endcase
    endfunction

    task automatic put_digits(input int n);
        repeat (n) str_buf.push_back(ipv_pkg::CHAR_DIGIT_LO + 16'($urandom_range(9)));
    endtask

    task automatic put_quad();
        for (int g = 0; g < 4; g++) begin
            if (g > 0) str_buf.push_back(ipv_pkg::CHAR_DOT);
            put_digits(($urandom_range(11) == 0) ? 4 : $urandom_range(1, 3));
        end
    endtask

    task automatic build_v6_text();
        int ngroups;
        int gap_at;
        bit quad;
        ngroups = $urandom_range(0, 8);
        gap_at  = ($urandom_range(2) == 0 || ngroups == 0) ? $urandom_range(0, ngroups) : -1;
        quad    = ($urandom_range(3) == 0);
        for (int i = 0; i < ngroups; i++) begin
            if (i == gap_at) begin
                str_buf.push_back(ipv_pkg::CHAR_COLON);
                str_buf.push_back(ipv_pkg::CHAR_COLON);
            end else if (i > 0) begin
                str_buf.push_back(ipv_pkg::CHAR_COLON);
            end
            repeat ($urandom_range(1, 4)) str_buf.push_back(rand_hex());
        end
        if (gap_at == ngroups) begin
            str_buf.push_back(ipv_pkg::CHAR_COLON);
            str_buf.push_back(ipv_pkg::CHAR_COLON);
        end
        if (quad) begin
            if (gap_at != ngroups) str_buf.push_back(ipv_pkg::CHAR_COLON);
            put_quad();
        end
    endtask

    // alter a generated string in one place
    task automatic mutate_text();
        int pos;
        if (str_buf.size() == 0) begin
            str_buf.push_back(pick_char());
        end else begin
            pos = $urandom_range(str_buf.size() - 1);
            case ($urandom_range(4))
                0: str_buf[pos] = pick_char();
                1: if (str_buf.size() > 1) str_buf.delete(pos);
                2: str_buf.insert(pos, pick_char());
                3: str_buf.insert(pos, str_buf[pos]);   // doubles the character at pos
                default: repeat ($urandom_range(1, 5)) str_buf.insert(pos, rand_hex());
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_ipv4_forms();
        send_text(ipv_pkg::OP_IPV4, "1.2.3.4");
        send_text(ipv_pkg::OP_IPV4, "999.10.0.255");   // no value check
        send_text(ipv_pkg::OP_IPV4, "1234.1.1.1");     // over-long dotted group
        send_text(ipv_pkg::OP_IPV4, "1.2.3");
        send_text(ipv_pkg::OP_IPV4, "1..2.3");
        send_text(ipv_pkg::OP_IPV6, "1.2.3.4");        // quad with no colon in front
        send_text(ipv_pkg::OP_IPV4, "::1.2.3.4");
    endtask

    task automatic test_ipv6_forms();
        send_text(ipv_pkg::OP_IPV6, "::");
        send_text(ipv_pkg::OP_IPV6, "::1.2.3.4");
        send_text(ipv_pkg::OP_IPV6, "ABCD:ef01::9");
        send_text(ipv_pkg::OP_IPV6, "12345::");        // over-long hex group
        send_text(ipv_pkg::OP_IPV6, "123456789");      // length counter saturates
        send_text(ipv_pkg::OP_IPV6, "a:");             // ends in one colon
        send_text(ipv_pkg::OP_IPV6, ":1");             // lone leading colon
        send_text(ipv_pkg::OP_IPV6, ":::");
        send_text(ipv_pkg::OP_IPV6, "1::2::3");        // second double colon
        send_text(ipv_pkg::OP_IPV6, "1:2.3.4.5");
        send_text(ipv_pkg::OP_IPV6, "a::b.2.3.4");     // letter in the quad's first group
    endtask

    task automatic test_odd_characters();
        send_text(ipv_pkg::OP_IPV6, "7");
        send_text(ipv_pkg::OP_IPV4, "7");
        send_text(ipv_pkg::OP_IPV6, ":");
        send_text(ipv_pkg::OP_IPV6, "1g::");
        str_buf.push_back(16'h0000);
        send_str(ipv_pkg::OP_IPV6);
        put_text("1:");
        str_buf.push_back(16'hFFFF);
        send_str(ipv_pkg::OP_IPV6);
        put_text("1:");
        str_buf.push_back(16'h8031);          // high bits set over a digit
        send_str(ipv_pkg::OP_IPV6);
    endtask

    // long receiver hold-off while strings keep coming back to back
    task automatic test_backpressure();
        wait_drain();
        @(negedge i_clk);
        hold_request = HOLD_CYCLES;
        sender_gaps  = 1'b0;
        for (int i = 0; i < 10; i++) begin
            if (i % 2 == 0) send_text(ipv_pkg::OP_IPV4, "1.2.3.4");
            else send_text(ipv_pkg::OP_IPV6, "::a");
        end
        sender_gaps = 1'b1;
        wait_drain();
    endtask

    task automatic test_random_strings();
        int target;
        int kind;
        logic op;
        target = chars_sent + RANDOM_ITEMS;
        while (chars_sent < target) begin
            // every fourth stretch runs the sender without gaps
            sender_gaps = ((chars_sent / 160) % 4) != 3;
            str_buf.delete();
            kind = $urandom_range(99);
            if (kind < 35) begin
                put_quad();
                op = ($urandom_range(6) == 0) ? ipv_pkg::OP_IPV6 : ipv_pkg::OP_IPV4;
            end else if (kind < 80) begin
                build_v6_text();
                op = ($urandom_range(6) == 0) ? ipv_pkg::OP_IPV4 : ipv_pkg::OP_IPV6;
            end else begin
                repeat ($urandom_range(1, 12)) str_buf.push_back(pick_char());
                op = 1'($urandom_range(1));
            end
            if (kind < 80 && $urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 2)) mutate_text();
            end
            send_str(op);
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_ipv4_forms();
        test_ipv6_forms();
        test_odd_characters();
        test_backpressure();
        test_random_strings();

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("ip_address_text_validator_core_tb passed");
        end else begin
            $display("ip_address_text_validator_core_tb failed");
        end
        $finish;
    end

endmodule
